@@ design/bdd_pkg.sv @@
// shared constants and types of the bdd bit-parallel evaluator
`default_nettype none

package bdd_pkg;

  // default sizes
  localparam int NODES_DEF = 1024;
  localparam int VARS_DEF  = 64;
  localparam int LANES_DEF = 64;

  // field widths
  localparam int OP_W   = 2;
  localparam int NODE_W = 10;
  localparam int VAR_W  = 6;
  localparam int REF_W  = 11;
  localparam int WORD_W = 64;
  localparam int LANE_IDX_W = 6;

  // input tdata layout, lowest field first
  localparam int NODE_LSB = 0;
  localparam int VAR_LSB  = NODE_LSB + NODE_W;
  localparam int LOW_LSB  = VAR_LSB + VAR_W;
  localparam int HIGH_LSB = LOW_LSB + REF_W;
  localparam int PAT_LSB  = HIGH_LSB + REF_W;
  localparam int ROOT_LSB = PAT_LSB + WORD_W;
  localparam int IN_USED_W = ROOT_LSB + REF_W;
  localparam int IN_DATA_W = ((IN_USED_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = WORD_W;

  // request kinds
  localparam logic [OP_W-1:0] OP_NODE    = 2'd0;
  localparam logic [OP_W-1:0] OP_PATTERN = 2'd1;
  localparam logic [OP_W-1:0] OP_EVAL    = 2'd2;

  // one node table entry
  typedef struct packed {
    logic [VAR_W-1:0] var_idx;
    logic [REF_W-1:0] high_ref;
    logic [REF_W-1:0] low_ref;
  } node_entry_t;

  localparam int NODE_ENTRY_W = VAR_W + 2 * REF_W;

endpackage

`default_nettype wire

@@ design/bdd_ram.sv @@
// generic ram with one write port and one registered read port
`default_nettype none

module bdd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ design/bdd_bitparallel_evaluator.sv @@
// top level: node and pattern tables with a shared lane walk sequencer
//
//  channel  dir  fields                                                  accepted when
//  s_axis   in   tuser: op; tdata: node_index, var_index, low_ref,       tvalid & tready
//                high_ref, pattern_word, root_ref
//  m_axis   out  tdata: result_word                                      tvalid & tready
//
// node and pattern writes are taken back to back while no evaluation runs.
// an evaluate request walks the lanes one after another through the single
// node-read then pattern-read step unit; no request is taken until it ends.
// the tables are not cleared by reset; rst_ni resets the sequencer and output.
// a finished word waits in the output register while loads are still taken;
// a following evaluate waits at its end until that register is free.
`default_nettype none

module bdd_bitparallel_evaluator #(
  parameter int NODES = bdd_pkg::NODES_DEF,
  parameter int VARS  = bdd_pkg::VARS_DEF,
  parameter int LANES = bdd_pkg::LANES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // node_index, var_index, low_ref, high_ref, pattern_word, root_ref, zero pad
  input  wire logic [bdd_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // op
  input  wire logic [bdd_pkg::OP_W-1:0]        s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // result_word
  output logic      [bdd_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o
);

  import bdd_pkg::*;

  localparam int NODE_AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int PAT_AW  = (VARS > 1) ? $clog2(VARS) : 1;
  localparam int LANE_W  = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int STEP_W  = $clog2(VARS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_VAR,
    ST_SEL,
    ST_FINISH
  } state_e;

  state_e state_q;

  logic [REF_W-1:0]  root_q;
  logic [REF_W-1:0]  ref_q;
  logic [STEP_W-1:0] steps_q;
  logic [LANE_W-1:0] lane_q;
  logic              var_ok_q;
  logic [WORD_W-1:0] acc_q;
  logic              out_valid_q;
  logic [WORD_W-1:0] out_data_q;

  // request fields
  logic              s_acc;
  logic [NODE_W-1:0] in_node;
  logic [VAR_W-1:0]  in_var;
  logic [REF_W-1:0]  in_low;
  logic [REF_W-1:0]  in_high;
  logic [WORD_W-1:0] in_pat;
  logic [REF_W-1:0]  in_root;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign in_node = s_axis_tdata_i[NODE_LSB +: NODE_W];
  assign in_var  = s_axis_tdata_i[VAR_LSB +: VAR_W];
  assign in_low  = s_axis_tdata_i[LOW_LSB +: REF_W];
  assign in_high = s_axis_tdata_i[HIGH_LSB +: REF_W];
  assign in_pat  = s_axis_tdata_i[PAT_LSB +: WORD_W];
  assign in_root = s_axis_tdata_i[ROOT_LSB +: REF_W];

  // table ports
  logic               node_we;
  logic [NODE_AW-1:0] node_raddr;
  node_entry_t        node_wdata;
  node_entry_t        node_rd;
  logic               pat_we;
  logic [PAT_AW-1:0]  pat_raddr;
  logic [WORD_W-1:0]  pat_rd;

  // terminal node is never written
  assign node_we = s_acc && (s_axis_tuser_i == OP_NODE) && (in_node != '0)
                   && (32'(in_node) < NODES);
  assign node_wdata = '{var_idx: in_var, high_ref: in_high, low_ref: in_low};
  assign pat_we  = s_acc && (s_axis_tuser_i == OP_PATTERN) && (32'(in_var) < VARS);

  bdd_ram #(
    .WIDTH (NODE_ENTRY_W),
    .DEPTH (NODES)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (NODE_AW'(in_node)),
    .wdata_i (node_wdata),
    .raddr_i (node_raddr),
    .rdata_o (node_rd)
  );

  bdd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (VARS)
  ) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (PAT_AW'(in_var)),
    .wdata_i (in_pat),
    .raddr_i (pat_raddr),
    .rdata_o (pat_rd)
  );

  // step unit: pick the child, then decide whether the lane ends here
  logic              sel_bit;
  logic [REF_W-1:0]  child_ref;
  logic [REF_W-1:0]  cand_ref;
  logic [STEP_W-1:0] cand_steps;
  logic [NODE_W-1:0] cand_node;
  logic              fin;
  logic              fin_bit;

  always_comb begin
    sel_bit   = var_ok_q && pat_rd[LANE_IDX_W'(lane_q)];
    child_ref = sel_bit ? node_rd.high_ref : node_rd.low_ref;
    if (state_q == ST_SEL) begin
      cand_ref   = child_ref ^ {{(REF_W-1){1'b0}}, ref_q[0]};
      cand_steps = steps_q + STEP_W'(1);
    end else begin
      cand_ref   = root_q;
      cand_steps = '0;
    end
    cand_node = cand_ref[REF_W-1:1];
    fin     = 1'b0;
    fin_bit = 1'b0;
    if (cand_node == '0) begin
      fin     = 1'b1;
      fin_bit = cand_ref[0];
    end else if (cand_steps == STEP_W'(VARS)) begin
      fin     = 1'b1;
      fin_bit = 1'b0;
    end else if (32'(cand_node) >= NODES) begin
      // missing node leads straight to the terminal with the same parity
      fin     = 1'b1;
      fin_bit = cand_ref[0];
    end
    if (state_q == ST_VAR) begin
      node_raddr = NODE_AW'(ref_q[REF_W-1:1]);
    end else begin
      node_raddr = NODE_AW'(cand_node);
    end
    pat_raddr = PAT_AW'(node_rd.var_idx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      root_q      <= '0;
      ref_q       <= '0;
      steps_q     <= '0;
      lane_q      <= '0;
      var_ok_q    <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && m_axis_tready_i && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_acc && (s_axis_tuser_i == OP_EVAL)) begin
            root_q  <= in_root;
            acc_q   <= '0;
            lane_q  <= '0;
            state_q <= ST_START;
          end
        end
        ST_START, ST_SEL: begin
          if (fin) begin
            acc_q[LANE_IDX_W'(lane_q)] <= fin_bit;
            if (lane_q == LANE_W'(LANES - 1)) begin
              state_q <= ST_FINISH;
            end else begin
              lane_q  <= lane_q + LANE_W'(1);
              state_q <= ST_START;
            end
          end else begin
            ref_q   <= cand_ref;
            steps_q <= cand_steps;
            state_q <= ST_VAR;
          end
        end
        ST_VAR: begin
          // variables past the pattern table read as all zero
          var_ok_q <= (32'(node_rd.var_idx) < VARS);
          state_q  <= ST_SEL;
        end
        ST_FINISH: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            out_data_q  <= acc_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // lanes past LANES never set a result bit
  a_unused_lanes_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((m_axis_tdata_o >> LANES) == '0))
    else $error("result bit set above the lane count");

  // walk never runs past the step limit
  a_step_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_VAR || state_q == ST_SEL) |-> (32'(steps_q) < VARS))
    else $error("walk step count beyond limit");

  // only real in-range nodes are read
  a_node_read_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_VAR) |-> ((ref_q[REF_W-1:1] != '0) && (32'(ref_q[REF_W-1:1]) < NODES)))
    else $error("node read of terminal or missing node");

  // lane counter stays inside the lane range
  a_lane_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (32'(lane_q) < LANES))
    else $error("lane index out of range");

  // a held result is not overwritten while it waits
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |=> (out_valid_q && $stable(out_data_q)))
    else $error("pending result changed");

endmodule

`default_nettype wire

@@ tb/bdd_bitparallel_evaluator_checker.sv @@
// checker for the bdd evaluator: mirrors the tables, predicts result words, compares them
module bdd_bitparallel_evaluator_checker
  import bdd_pkg::*;
#(
  parameter int NODES = NODES_DEF,
  parameter int VARS  = VARS_DEF,
  parameter int LANES = LANES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  input  logic                  s_axis_tready_i,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic [OP_W-1:0]       s_axis_tuser_i,
  input  logic                  m_axis_tvalid_i,
  input  logic                  m_axis_tready_i,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    words_checked_o
);

  logic [VAR_W-1:0]  node_var_tab  [NODES];
  logic [REF_W-1:0]  node_low_tab  [NODES];
  logic [REF_W-1:0]  node_high_tab [NODES];
  logic [WORD_W-1:0] pattern_tab   [VARS];

  logic [WORD_W-1:0] pending_words [$];

  // walk every lane from the root, flipping parity on complemented edges
  function automatic logic [WORD_W-1:0] eval_word(logic [REF_W-1:0] root);
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] pw;
    logic [REF_W-1:0]  cur;
    logic [REF_W-1:0]  nxt;
    int                nd;
    bit                done;
    word = '0;
    for (int lane = 0; lane < LANES && lane < WORD_W; lane++) begin
      cur  = root;
      done = 0;
      for (int step = 0; step <= VARS && !done; step++) begin
        nd = int'(cur[REF_W-1:1]);
        if (nd == 0) begin
          word[lane] = cur[0];
          done = 1;
        end else if (step == VARS) begin
          // walk too long: lane stays 0
          done = 1;
        end else begin
          if (nd >= NODES) begin
            nxt = '0;
          end else begin
            pw  = (int'(node_var_tab[nd]) < VARS) ? pattern_tab[node_var_tab[nd]] : '0;
            nxt = pw[lane] ? node_high_tab[nd] : node_low_tab[nd];
          end
          cur = nxt ^ {{(REF_W-1){1'b0}}, cur[0]};
        end
      end
    end
    return word;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic [NODE_W-1:0] nidx;
    logic [VAR_W-1:0]  vidx;
    logic [WORD_W-1:0] want;
    if (!rst_ni) begin
      pending_words.delete();
      pending_o = 0;
    end else begin
      // outgoing word first: it always belongs to an earlier request
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (pending_words.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("mismatch: result_word %h arrived with no evaluation pending",
                     m_axis_tdata_i);
        end else begin
          want = pending_words.pop_front();
          words_checked_o++;
          if (m_axis_tdata_i !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("mismatch: result_word expected %h got %h", want, m_axis_tdata_i);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        nidx = s_axis_tdata_i[NODE_LSB +: NODE_W];
        vidx = s_axis_tdata_i[VAR_LSB +: VAR_W];
        case (s_axis_tuser_i)
          OP_NODE: begin
            // the terminal entry is never written
            if (nidx != '0 && int'(nidx) < NODES) begin
              node_var_tab[nidx]  = vidx;
              node_low_tab[nidx]  = s_axis_tdata_i[LOW_LSB +: REF_W];
              node_high_tab[nidx] = s_axis_tdata_i[HIGH_LSB +: REF_W];
            end
          end
          OP_PATTERN: begin
            if (int'(vidx) < VARS)
              pattern_tab[vidx] = s_axis_tdata_i[PAT_LSB +: WORD_W];
          end
          OP_EVAL: begin
            pending_words = {pending_words, eval_word(s_axis_tdata_i[ROOT_LSB +: REF_W])};
          end
          default: begin
          end
        endcase
      end
      pending_o = pending_words.size();
    end
  end

endmodule

@@ tb/bdd_bitparallel_evaluator_tb.sv @@
// testbench top for the bdd evaluator: request stimulus, output stalls, watchdog, verdict
module bdd_bitparallel_evaluator_tb;
  import bdd_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int HOLD_CYCLES    = 600;
  localparam int END_WAIT       = 8300;
  localparam int RAND_ITEMS     = 118;
  localparam int CALM_FROM      = 96;
  localparam int HOLD_AT        = 40;
  localparam int HOLD_BURST     = 6;
  localparam int DRAIN_AT       = 70;

  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic [OP_W-1:0]       s_tuser  = '0;
  logic                  s_tready;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  int fail_count;
  int pending;
  int words_checked;

  bit idle_en  = 1'b1;
  bit hold_req = 1'b0;
  int quiet_cyc = 0;

  // which entries hold data, so no walk ever reads an unwritten one
  bit node_ok [NODES_DEF];
  int live_nodes [$];
  bit pat_ok [VARS_DEF];
  int pat_list [$];

  int n_node  = 0;
  int n_pat   = 0;
  int n_eval  = 0;
  int n_noise = 0;

  bdd_bitparallel_evaluator dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  bdd_bitparallel_evaluator_checker checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .words_checked_o (words_checked)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cyc <= 0;
    else quiet_cyc <= quiet_cyc + 1;
  end

  initial begin
    wait (quiet_cyc >= WATCHDOG_LIMIT);
    $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // result side: short random stalls, one long hold on request
  initial begin : rx
    int k;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (idle_en && $urandom_range(3) == 0) begin
        k = $urandom_range(4, 1);
        m_tready <= 1'b0;
        repeat (k - 1) @(negedge clk);
      end else begin
        k = $urandom_range(8, 1);
        m_tready <= 1'b1;
        repeat (k - 1) @(negedge clk);
      end
    end
  end

  function automatic logic [WORD_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_req(
    logic [NODE_W-1:0] nd, logic [VAR_W-1:0] vr, logic [REF_W-1:0] lo,
    logic [REF_W-1:0] hi, logic [WORD_W-1:0] pw, logic [REF_W-1:0] rt);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[NODE_LSB +: NODE_W] = nd;
    d[VAR_LSB  +: VAR_W]  = vr;
    d[LOW_LSB  +: REF_W]  = lo;
    d[HIGH_LSB +: REF_W]  = hi;
    d[PAT_LSB  +: WORD_W] = pw;
    d[ROOT_LSB +: REF_W]  = rt;
    return d;
  endfunction

  task automatic send_req(logic [OP_W-1:0] op, logic [IN_DATA_W-1:0] data);
    int gap;
    if (idle_en && $urandom_range(3) == 0) begin
      gap = $urandom_range(4, 1);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= data;
    do @(posedge clk); while (!(s_tvalid && s_tready));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic node_wr(int nd, int vr, int lo, int hi);
    send_req(OP_NODE, pack_req(NODE_W'(nd), VAR_W'(vr), REF_W'(lo), REF_W'(hi),
                               rand64(), REF_W'($urandom)));
    if (!node_ok[nd]) begin
      node_ok[nd] = 1'b1;
      live_nodes = {live_nodes, nd};
    end
    n_node++;
  endtask

  task automatic pat_wr(int vr, logic [WORD_W-1:0] pw);
    send_req(OP_PATTERN, pack_req(NODE_W'($urandom), VAR_W'(vr), REF_W'($urandom),
                                  REF_W'($urandom), pw, REF_W'($urandom)));
    if (!pat_ok[vr]) begin
      pat_ok[vr] = 1'b1;
      pat_list = {pat_list, vr};
    end
    n_pat++;
  endtask

  task automatic eval_rt(int rt);
    send_req(OP_EVAL, pack_req(NODE_W'($urandom), VAR_W'($urandom), REF_W'($urandom),
                               REF_W'($urandom), rand64(), REF_W'(rt)));
    n_eval++;
  endtask

  // requests the block ignores: unused op code and terminal writes
  task automatic send_noise();
    if ($urandom_range(1))
      send_req(OP_UNUSED, pack_req(NODE_W'($urandom), VAR_W'($urandom), REF_W'($urandom),
                                   REF_W'($urandom), rand64(), REF_W'($urandom)));
    else
      send_req(OP_NODE, pack_req('0, VAR_W'($urandom), REF_W'($urandom),
                                 REF_W'($urandom), rand64(), REF_W'($urandom)));
    n_noise++;
  endtask

  function automatic int pick_child(int self_nd);
    int r;
    r = $urandom_range(99);
    if (r < 35 || live_nodes.size() == 0) return $urandom_range(1);
    if (r < 40) return self_nd * 2 + $urandom_range(1);
    return live_nodes[$urandom_range(live_nodes.size() - 1)] * 2 + $urandom_range(1);
  endfunction

  function automatic int rand_root();
    if (live_nodes.size() == 0 || $urandom_range(6) == 0) return $urandom_range(1);
    return live_nodes[$urandom_range(live_nodes.size() - 1)] * 2 + $urandom_range(1);
  endfunction

  task automatic rand_pat_wr();
    int r;
    logic [WORD_W-1:0] pw;
    r  = $urandom_range(9);
    pw = (r == 0) ? '0 : (r == 1) ? '1 : rand64();
    pat_wr($urandom_range(VARS_DEF - 1), pw);
  endtask

  // new nodes only point at written nodes, at themselves or at the terminal
  task automatic rand_node_wr();
    int nd;
    if (pat_list.size() == 0) begin
      rand_pat_wr();
    end else begin
      if (live_nodes.size() > 0 && $urandom_range(1))
        nd = live_nodes[$urandom_range(live_nodes.size() - 1)];
      else
        nd = $urandom_range(NODES_DEF - 1, 1);
      node_wr(nd, pat_list[$urandom_range(pat_list.size() - 1)],
              pick_child(nd), pick_child(nd));
    end
  endtask

  initial begin : stim
    int r;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // constants need no table reads
    eval_rt(0);
    eval_rt(1);
    pat_wr(0, '1);
    pat_wr(63, '0);
    pat_wr(1, 64'haaaa_aaaa_aaaa_aaaa);
    pat_wr(62, 64'h5555_5555_5555_5555);
    node_wr(1, 0, 0, 1);
    eval_rt(2);
    eval_rt(3);
    // complemented high edge
    node_wr(2, 1, 2, 3);
    eval_rt(4);
    eval_rt(5);
    // complemented self loop never reaches the terminal
    node_wr(1023, 63, 2047, 2047);
    eval_rt(2046);
    eval_rt(2047);
    node_wr(1022, 62, 5, 2046);
    eval_rt(2044);
    // write to the terminal entry is dropped
    send_req(OP_NODE, pack_req('0, 63, 2047, 2047, '1, 2047));
    n_noise++;
    eval_rt(3);
    send_req(OP_UNUSED, pack_req('1, '1, '1, '1, '1, '1));
    n_noise++;
    node_wr(1, 63, 1, 0);
    eval_rt(5);
    eval_rt(2045);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == CALM_FROM) idle_en = 1'b0;
      if (i == DRAIN_AT) wait_drained();
      if ($urandom_range(19) == 0) send_noise();
      if (i >= HOLD_AT && i < HOLD_AT + HOLD_BURST) begin
        // short evaluations in a row while the result side holds off
        if (i == HOLD_AT) begin
          wait_drained();
          hold_req = 1'b1;
        end
        eval_rt($urandom_range(1));
      end else begin
        r = $urandom_range(99);
        if (r < 28) rand_pat_wr();
        else if (r < 60) rand_node_wr();
        else eval_rt(rand_root());
      end
    end

    wait_drained();
    repeat (END_WAIT) @(negedge clk);

    $display("covered %0d node writes, %0d pattern writes, %0d evaluations, %0d ignored requests",
             n_node, n_pat, n_eval, n_noise);
    $display("%0d result words compared, including loops, complement edges and a long output hold",
             words_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
